// File: hw/rtl/npl_pkg.sv
// Shared constants and types of the nearest plane hit block.
// Used by the item and configuration interfaces, the intersection unit and the top level.
package npl_pkg;

    localparam int PLANES   = 16;
    localparam int PLANE_AW = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int CNT_W    = $clog2(PLANES + 1);
    localparam int SLOT_W   = 4;
    localparam int CFG_AW   = 3;

    localparam logic [CFG_AW-1:0] CFG_CAMERA_X       = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_CAMERA_Y       = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_CAMERA_Z       = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_PLANES_IN_USE  = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_PARALLEL_LIMIT = 3'd4;

    localparam logic [31:0] PARALLEL_LIMIT_RESET = 32'd4295;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec3_t;

    typedef struct packed {
        logic start;
    } isect_req_t;

    typedef struct packed {
        logic        done;
        logic        valid;
        logic [31:0] t;
    } isect_rsp_t;

endpackage

// File: hw/rtl/npl_item_if.sv
// Input word channel: plane loads and ray traces.
// Depends on npl_pkg for the slot width.
interface npl_item_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [npl_pkg::SLOT_W-1:0]    plane_slot;
    logic signed [31:0]            point_x;
    logic signed [31:0]            point_y;
    logic signed [31:0]            point_z;
    logic signed [31:0]            normal_x;
    logic signed [31:0]            normal_y;
    logic signed [31:0]            normal_z;
    logic signed [31:0]            dir_x;
    logic signed [31:0]            dir_y;
    logic signed [31:0]            dir_z;

    modport source (output valid, mode, plane_slot, point_x, point_y, point_z,
                    normal_x, normal_y, normal_z, dir_x, dir_y, dir_z, input ready);
    modport sink (input valid, mode, plane_slot, point_x, point_y, point_z,
                  normal_x, normal_y, normal_z, dir_x, dir_y, dir_z, output ready);
endinterface

// File: hw/rtl/npl_result_if.sv
// Result word channel: hit flag, plane index and hit point.
// Self-contained apart from the Q16.16 field widths.
interface npl_result_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic [3:0]         hit_plane;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;

    modport source (output valid, hit, hit_plane, hit_x, hit_y, hit_z, input ready);
    modport sink (input valid, hit, hit_plane, hit_x, hit_y, hit_z, output ready);
endinterface

// File: hw/rtl/npl_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on npl_pkg for the index width.
interface npl_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [npl_pkg::CFG_AW-1:0] addr;
    logic [31:0]                data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

// File: hw/rtl/npl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module npl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: hw/rtl/npl_isect.sv
// Ray/plane intersection unit: two dot products on one shared multiplier,
// the parallel and behind tests, and a bit-serial divider for t.
// Depends on npl_pkg.
module npl_isect (
    input  logic                clk,
    input  logic                rst_n,
    input  npl_pkg::isect_req_t req,
    input  npl_pkg::vec3_t      point,
    input  npl_pkg::vec3_t      normal,
    input  npl_pkg::vec3_t      dir,
    input  npl_pkg::vec3_t      origin,
    input  logic [31:0]         limit,
    output npl_pkg::isect_rsp_t rsp
);
    localparam logic [1:0] I_IDLE = 2'd0;
    localparam logic [1:0] I_MUL  = 2'd1;
    localparam logic [1:0] I_CHK  = 2'd2;
    localparam logic [1:0] I_DIV  = 2'd3;

    logic [1:0]         state_reg;
    logic [2:0]         step_reg;
    logic [4:0]         cnt_reg;
    logic signed [65:0] prod_reg;
    logic signed [65:0] den_reg;
    logic signed [67:0] num_reg;
    logic [63:0]        aden_reg;
    logic [63:0]        rem_reg;
    logic [31:0]        low_reg;
    logic [31:0]        q_reg;
    logic               done_reg;
    logic               valid_reg;
    logic [31:0]        t_reg;

    logic signed [32:0] op_a;
    logic signed [32:0] op_b;
    logic signed [65:0] prod_c;
    logic [2:0]         prev_step;
    logic signed [65:0] neg_den;
    logic signed [67:0] neg_num;
    logic [63:0]        aden;
    logic [64:0]        anum;
    logic               skip;
    logic               sat;
    logic [64:0]        rem2;
    logic               ge;
    logic [64:0]        diff;

    // Operand pair per step: three terms of n.d, then three of (P-O).n.
    always_comb
    begin
        case (step_reg)
            3'd0:
            begin
                op_a = {normal.x[31], normal.x};
                op_b = {dir.x[31], dir.x};
            end
            3'd1:
            begin
                op_a = {normal.y[31], normal.y};
                op_b = {dir.y[31], dir.y};
            end
            3'd2:
            begin
                op_a = {normal.z[31], normal.z};
                op_b = {dir.z[31], dir.z};
            end
            3'd3:
            begin
                op_a = {point.x[31], point.x} - {origin.x[31], origin.x};
                op_b = {normal.x[31], normal.x};
            end
            3'd4:
            begin
                op_a = {point.y[31], point.y} - {origin.y[31], origin.y};
                op_b = {normal.y[31], normal.y};
            end
            default:
            begin
                op_a = {point.z[31], point.z} - {origin.z[31], origin.z};
                op_b = {normal.z[31], normal.z};
            end
        endcase
    end

    assign prod_c    = op_a * op_b;
    assign prev_step = step_reg - 3'd1;

    assign neg_den = -den_reg;
    assign neg_num = -num_reg;
    assign aden    = den_reg[65] ? neg_den[63:0] : den_reg[63:0];
    assign anum    = num_reg[67] ? neg_num[64:0] : num_reg[64:0];
    assign skip    = (aden == 64'd0) || (aden < {32'd0, limit})
                     || ((num_reg != 68'sd0) && (num_reg[67] != den_reg[65]));
    // The quotient overflows 32 bits exactly when |num| / 2^16 reaches |den|.
    assign sat     = {15'd0, anum[64:16]} >= aden;

    assign rem2 = {rem_reg, low_reg[31]};
    assign ge   = rem2 >= {1'b0, aden_reg};
    assign diff = rem2 - {1'b0, aden_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= I_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                I_IDLE:
                begin
                    if (req.start)
                    begin
                        state_reg <= I_MUL;
                    end
                end
                I_MUL:
                begin
                    if (step_reg == 3'd6)
                    begin
                        state_reg <= I_CHK;
                    end
                end
                I_CHK:
                begin
                    if (skip || sat)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= I_IDLE;
                    end
                    else
                    begin
                        state_reg <= I_DIV;
                    end
                end
                I_DIV:
                begin
                    if (cnt_reg == 5'd31)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= I_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= I_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            I_IDLE:
            begin
                step_reg <= 3'd0;
                den_reg  <= '0;
                num_reg  <= '0;
            end
            I_MUL:
            begin
                prod_reg <= prod_c;
                step_reg <= step_reg + 3'd1;
                if (step_reg != 3'd0)
                begin
                    if (prev_step < 3'd3)
                    begin
                        den_reg <= den_reg + prod_reg;
                    end
                    else
                    begin
                        num_reg <= num_reg + {{2{prod_reg[65]}}, prod_reg};
                    end
                end
            end
            I_CHK:
            begin
                valid_reg <= !skip;
                t_reg     <= 32'hFFFF_FFFF;
                aden_reg  <= aden;
                rem_reg   <= {15'd0, anum[64:16]};
                low_reg   <= {anum[15:0], 16'd0};
                q_reg     <= '0;
                cnt_reg   <= '0;
            end
            default:
            begin
                rem_reg <= ge ? diff[63:0] : rem2[63:0];
                low_reg <= {low_reg[30:0], 1'b0};
                q_reg   <= {q_reg[30:0], ge};
                t_reg   <= {q_reg[30:0], ge};
                cnt_reg <= cnt_reg + 5'd1;
            end
        endcase
    end

    assign rsp.done  = done_reg;
    assign rsp.valid = valid_reg;
    assign rsp.t     = t_reg;
endmodule

// File: hw/rtl/nearest_plane_hit.sv
// Nearest ray/plane hit over a table of npl_pkg::PLANES planes. A load word
// (mode 0) writes one plane, a point and a normal in Q16.16, into on-chip RAM
// and gives no result. A trace word (mode 1) casts a ray from the camera
// origin along its direction, tests the first planes_in_use entries (at most
// PLANES) and returns one result word: the hit flag, the index of the nearest
// plane in front of the origin (lowest index on a tie) and the saturated hit
// point. Words are handled one at a time. For each plane searched, the RAM
// rows are read, the intersection unit is started and the sequencer waits on
// it; the unit forms the dot products on its one shared multiplier, runs the
// tests and, unless the plane is skipped or t saturates, a bit-serial
// division. The hit point is then formed on a second multiplier, and a last
// step loads the output register; the next word can be accepted after that.
// A result word that is not taken holds the next trace at that last
// step. Planes must be loaded before they are searched; the table has no
// reset value.
// Depends on npl_pkg, the three channel interfaces, npl_ram and npl_isect.
module nearest_plane_hit (
    input  logic clk,
    input  logic rst_n,
    npl_item_if.sink     item,
    npl_result_if.source result,
    npl_cfg_if.sink      cfg
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_GO   = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_CRD  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    // Configuration registers.
    npl_pkg::vec3_t origin_reg;
    logic [4:0]     in_use_reg;
    logic [31:0]    limit_reg;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [npl_pkg::CNT_W-1:0]   idx_reg;
    logic [npl_pkg::CNT_W-1:0]   idx_next;
    logic [npl_pkg::CNT_W-1:0]   count_reg;
    npl_pkg::vec3_t              dir_reg;
    logic                        found_reg;
    logic [npl_pkg::CNT_W-1:0]   best_i_reg;
    logic [31:0]                 best_t_reg;
    logic [2:0]                  cstep_reg;
    logic signed [65:0]          cprod_reg;
    logic signed [31:0]          coord_reg [3];

    logic                        out_valid_reg;
    logic                        out_hit_reg;
    logic [3:0]                  out_plane_reg;
    logic signed [31:0]          out_x_reg;
    logic signed [31:0]          out_y_reg;
    logic signed [31:0]          out_z_reg;

    logic                        item_acc;
    logic                        load_ok;
    logic [31:0]                 count_full;
    logic [npl_pkg::CNT_W-1:0]   count_now;

    logic [95:0]                 point_row;
    logic [95:0]                 normal_row;
    npl_pkg::isect_req_t         isect_req;
    npl_pkg::isect_rsp_t         isect_rsp;

    logic signed [32:0]          c_a;
    logic signed [65:0]          c_prod;
    logic signed [31:0]          c_org;
    logic [2:0]                  cprev;
    logic signed [48:0]          c_sum;
    logic signed [31:0]          c_sat;

    assign item.ready = (state_reg == S_IDLE);
    assign item_acc   = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    assign load_ok    = ({{(32 - npl_pkg::SLOT_W){1'b0}}, item.plane_slot} < npl_pkg::PLANES);
    assign count_full = ({27'd0, in_use_reg} > npl_pkg::PLANES) ? npl_pkg::PLANES
                                                                 : {27'd0, in_use_reg};
    assign count_now  = count_full[npl_pkg::CNT_W-1:0];

    // Each table row holds one plane: x in the high word, z in the low word.
    npl_ram #(.WIDTH(96), .DEPTH(npl_pkg::PLANES)) u_point_ram (
        .clk   (clk),
        .we    (item_acc && !item.mode && load_ok),
        .waddr (npl_pkg::PLANE_AW'(item.plane_slot)),
        .wdata ({item.point_x, item.point_y, item.point_z}),
        .re    (state_reg == S_RD),
        .raddr (npl_pkg::PLANE_AW'(idx_reg)),
        .rdata (point_row)
    );

    npl_ram #(.WIDTH(96), .DEPTH(npl_pkg::PLANES)) u_normal_ram (
        .clk   (clk),
        .we    (item_acc && !item.mode && load_ok),
        .waddr (npl_pkg::PLANE_AW'(item.plane_slot)),
        .wdata ({item.normal_x, item.normal_y, item.normal_z}),
        .re    (state_reg == S_RD),
        .raddr (npl_pkg::PLANE_AW'(idx_reg)),
        .rdata (normal_row)
    );

    // The read rows stay put while the unit works, since no other read is
    // issued until it reports done.
    assign isect_req.start = (state_reg == S_GO);

    npl_isect u_isect (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (isect_req),
        .point  (point_row),
        .normal (normal_row),
        .dir    (dir_reg),
        .origin (origin_reg),
        .limit  (limit_reg),
        .rsp    (isect_rsp)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg <= '0;
            in_use_reg <= '0;
            limit_reg  <= npl_pkg::PARALLEL_LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.addr)
                npl_pkg::CFG_CAMERA_X:       origin_reg.x <= cfg.data;
                npl_pkg::CFG_CAMERA_Y:       origin_reg.y <= cfg.data;
                npl_pkg::CFG_CAMERA_Z:       origin_reg.z <= cfg.data;
                npl_pkg::CFG_PLANES_IN_USE:  in_use_reg   <= cfg.data[4:0];
                npl_pkg::CFG_PARALLEL_LIMIT: limit_reg    <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer: one plane at a time through the intersection unit.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                if (item_acc && item.mode)
                begin
                    state_next = (count_now == '0) ? S_CRD : S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_GO;
            end
            S_GO:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (isect_rsp.done)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = (idx_next == count_reg) ? S_CRD : S_RD;
                end
            end
            S_CRD:
            begin
                if (cstep_reg == 3'd3)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Hit point: O_k + floor(d_k * t / 2^16), saturated to 32 bits.
    always_comb
    begin
        case (cstep_reg)
            3'd0:    c_a = {dir_reg.x[31], dir_reg.x};
            3'd1:    c_a = {dir_reg.y[31], dir_reg.y};
            default: c_a = {dir_reg.z[31], dir_reg.z};
        endcase
    end

    assign c_prod = c_a * $signed({1'b0, best_t_reg});
    assign cprev  = cstep_reg - 3'd1;

    always_comb
    begin
        case (cprev)
            3'd0:    c_org = origin_reg.x;
            3'd1:    c_org = origin_reg.y;
            default: c_org = origin_reg.z;
        endcase
        c_sum = {{17{c_org[31]}}, c_org} + {cprod_reg[63], cprod_reg[63:16]};
        if (c_sum > 49'sd2147483647)
        begin
            c_sat = 32'sh7FFF_FFFF;
        end
        else if (c_sum < -49'sd2147483648)
        begin
            c_sat = 32'sh8000_0000;
        end
        else
        begin
            c_sat = c_sum[31:0];
        end
    end

    // Search bookkeeping and the hit point datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                dir_reg   <= {item.dir_x, item.dir_y, item.dir_z};
                count_reg <= count_now;
                found_reg <= 1'b0;
                cstep_reg <= '0;
            end
            S_WAIT:
            begin
                if (isect_rsp.done && isect_rsp.valid
                    && (!found_reg || (isect_rsp.t < best_t_reg)))
                begin
                    found_reg  <= 1'b1;
                    best_t_reg <= isect_rsp.t;
                    best_i_reg <= idx_reg;
                end
            end
            S_CRD:
            begin
                cprod_reg <= c_prod;
                cstep_reg <= cstep_reg + 3'd1;
                if (cstep_reg != 3'd0)
                begin
                    coord_reg[cprev[1:0]] <= c_sat;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register: the result waits here while the next word is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_FIN && !out_valid_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN && !out_valid_reg)
        begin
            out_hit_reg   <= found_reg;
            out_plane_reg <= found_reg ? 4'(best_i_reg) : 4'd0;
            out_x_reg     <= found_reg ? coord_reg[0] : 32'sd0;
            out_y_reg     <= found_reg ? coord_reg[1] : 32'sd0;
            out_z_reg     <= found_reg ? coord_reg[2] : 32'sd0;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.hit       = out_hit_reg;
    assign result.hit_plane = out_plane_reg;
    assign result.hit_x     = out_x_reg;
    assign result.hit_y     = out_y_reg;
    assign result.hit_z     = out_z_reg;
endmodule

// File: sim/npl_checker.sv
// Result checker for nearest_plane_hit: watches the config, input and result channels.
// Depends on npl_pkg and the three channel interfaces; predicts each trace and compares.
`timescale 1ns / 100ps

module npl_checker #(
    parameter bit TRACE_MODE = 1'b1
) (
    input  logic   clk,
    input  logic   rst_n,
    npl_item_if    item,
    npl_result_if  result,
    npl_cfg_if     cfg,
    output int     errors,
    output int     pending
);
    import npl_pkg::*;

    typedef struct packed {
        logic               hit;
        logic [3:0]         plane;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } hit_word_t;

    logic signed [31:0] camera [3];
    logic [4:0]         planes_used;
    logic [31:0]        par_limit;
    logic signed [31:0] pt [PLANES][3];
    logic signed [31:0] nm [PLANES][3];
    hit_word_t          expected_hits [$];

    // Origin plus d*t with floor rounding, clamped to the signed 32-bit range.
    function automatic logic signed [31:0] hit_coord(input logic signed [31:0] o,
                                                     input logic signed [31:0] d,
                                                     input logic [31:0] t);
        logic signed [127:0] p;
        logic signed [127:0] v;
        logic signed [127:0] oe;
        p  = d;
        p  = p * $signed({96'b0, t});
        oe = o;
        v  = oe + (p >>> 16);
        if (v > 128'sh7FFFFFFF)
            return 32'sh7FFFFFFF;
        if (v < -128'sh80000000)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic hit_word_t nearest_hit(input logic signed [31:0] dx,
                                              input logic signed [31:0] dy,
                                              input logic signed [31:0] dz);
        logic signed [31:0]  d [3];
        logic signed [127:0] a, b, den, num, aden, anum, q;
        logic [31:0]         t, best_t;
        bit                  found;
        int                  best_i, cnt;
        hit_word_t           r;
        d[0] = dx; d[1] = dy; d[2] = dz;
        found = 0; best_t = 0; best_i = 0;
        cnt = (planes_used > PLANES) ? PLANES : planes_used;
        for (int i = 0; i < cnt; i++)
        begin
            den = 0;
            num = 0;
            for (int k = 0; k < 3; k++)
            begin
                a = nm[i][k];
                b = d[k];
                den += a * b;
                b = pt[i][k];
                q = camera[k];
                num += (b - q) * a;
            end
            aden = (den < 0) ? -den : den;
            // A plane seen edge-on is skipped, as is one behind the origin.
            if (aden == 0 || aden < $signed({96'b0, par_limit}))
                continue;
            if (num != 0 && ((num < 0) != (den < 0)))
                continue;
            anum = (num < 0) ? -num : num;
            q = (anum <<< 16) / aden;
            t = (q > 128'shFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
            if (!found || t < best_t)
            begin
                found  = 1;
                best_t = t;
                best_i = i;
            end
        end
        r = '0;
        if (found)
        begin
            r.hit   = 1'b1;
            r.plane = best_i[3:0];
            r.x     = hit_coord(camera[0], d[0], best_t);
            r.y     = hit_coord(camera[1], d[1], best_t);
            r.z     = hit_coord(camera[2], d[2], best_t);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hit_word_t e;
        if (!rst_n)
        begin
            camera[0] = 0; camera[1] = 0; camera[2] = 0;
            planes_used = 0;
            par_limit = PARALLEL_LIMIT_RESET;
            expected_hits.delete();
            errors = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.addr)
                    CFG_CAMERA_X:       camera[0] = cfg.data;
                    CFG_CAMERA_Y:       camera[1] = cfg.data;
                    CFG_CAMERA_Z:       camera[2] = cfg.data;
                    CFG_PLANES_IN_USE:  planes_used = cfg.data[4:0];
                    CFG_PARALLEL_LIMIT: par_limit = cfg.data;
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
            begin
                if (item.mode == TRACE_MODE)
                    expected_hits.push_back(nearest_hit(item.dir_x, item.dir_y, item.dir_z));
                else if (item.plane_slot < PLANES)
                begin
                    pt[item.plane_slot][0] = item.point_x;
                    pt[item.plane_slot][1] = item.point_y;
                    pt[item.plane_slot][2] = item.point_z;
                    nm[item.plane_slot][0] = item.normal_x;
                    nm[item.plane_slot][1] = item.normal_y;
                    nm[item.plane_slot][2] = item.normal_z;
                end
            end
            if (result.valid && result.ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    $error("result word with no trace outstanding");
                    errors++;
                end
                else
                begin
                    e = expected_hits.pop_front();
                    if (result.hit !== e.hit)
                    begin
                        $error("hit expected %0d got %0d", e.hit, result.hit);
                        errors++;
                    end
                    if (result.hit_plane !== e.plane)
                    begin
                        $error("hit_plane expected %0d got %0d", e.plane, result.hit_plane);
                        errors++;
                    end
                    if (result.hit_x !== e.x)
                    begin
                        $error("hit_x expected %0d got %0d", e.x, result.hit_x);
                        errors++;
                    end
                    if (result.hit_y !== e.y)
                    begin
                        $error("hit_y expected %0d got %0d", e.y, result.hit_y);
                        errors++;
                    end
                    if (result.hit_z !== e.z)
                    begin
                        $error("hit_z expected %0d got %0d", e.z, result.hit_z);
                        errors++;
                    end
                end
            end
        end
        pending = expected_hits.size();
    end

endmodule

// File: sim/tb_top.sv
// Top of the nearest_plane_hit testbench: clock, reset, stimulus and verdict.
// Depends on npl_pkg, the channel interfaces, the block itself and npl_checker.
`timescale 1ns / 100ps

module tb_top;
    import npl_pkg::*;

    localparam bit MODE_LOAD  = 1'b0;
    localparam bit MODE_TRACE = 1'b1;
    localparam int ONE        = 32'sh10000;   // 1.0 in Q16.16
    // Far above the slowest legal run: 16 planes searched for every one of
    // roughly 1600 words, plus long receiver stalls.
    localparam int CYCLE_LIMIT = 6000000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   cycles;
    bit   calm;       // when set, neither side inserts idle cycles
    bit   stall_now;  // asks the result side for one long hold-off

    npl_item_if   item ();
    npl_result_if result ();
    npl_cfg_if    cfg ();

    nearest_plane_hit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    npl_checker #(.TRACE_MODE(MODE_TRACE)) u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .result  (result),
        .cfg     (cfg),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 9);
        if (calm || r < 6)
            return 0;
        if (r < 9)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Q16.16 value: small coordinates most of the time so that real hits
    // happen, with full-range noise and the extremes mixed in.
    function automatic logic signed [31:0] q_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return $urandom;
        if (r == 2)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh7FFFFFFF;
                1: return 32'sh80000000;
                2: return 0;
                default: return -1;
            endcase
        end
        return $signed($urandom_range(0, 40 * ONE)) - 20 * ONE;
    endfunction

    // Result side. The long hold-off is counted here, while the sender keeps
    // offering words, so the block backs up and stalls its input.
    initial
    begin
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_now)
            begin
                result.ready <= 1'b0;
                repeat (3000) @(posedge clk);
                stall_now = 0;
                result.ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                result.ready <= 1'b0;
                repeat (idle_len() + 1) @(posedge clk);
                result.ready <= 1'b1;
            end
            else
                result.ready <= 1'b1;
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // One input word. Valid stays high straight into the next word when no
    // gap follows, so it is never lowered and raised in the same step.
    task automatic send_word(input bit mode, input logic [3:0] slot,
                             input logic signed [31:0] px, py, pz,
                             input logic signed [31:0] nx, ny, nz,
                             input logic signed [31:0] dx, dy, dz);
        int gap;
        item.valid      <= 1'b1;
        item.mode       <= mode;
        item.plane_slot <= slot;
        item.point_x    <= px;
        item.point_y    <= py;
        item.point_z    <= pz;
        item.normal_x   <= nx;
        item.normal_y   <= ny;
        item.normal_z   <= nz;
        item.dir_x      <= dx;
        item.dir_y      <= dy;
        item.dir_z      <= dz;
        do @(posedge clk); while (!item.ready);
        gap = idle_len();
        if (gap > 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic load_plane(input logic [3:0] slot,
                              input logic signed [31:0] px, py, pz,
                              input logic signed [31:0] nx, ny, nz);
        send_word(MODE_LOAD, slot, px, py, pz, nx, ny, nz,
                  $urandom, $urandom, $urandom);
    endtask

    task automatic trace(input logic signed [31:0] dx, dy, dz);
        send_word(MODE_TRACE, 4'($urandom), $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, dx, dy, dz);
    endtask

    // Waits on the falling edge so the checker has settled its count. Loads
    // give no result, so a closing wait covers one still in flight.
    task automatic drain();
        item.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Valid drops for one cycle after each write, so back-to-back writes
    // never raise and lower it in the same step.
    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [31:0] data);
        cfg.valid <= 1'b1;
        cfg.addr  <= idx;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_camera(input logic [31:0] x, y, z);
        write_reg(CFG_CAMERA_X, x);
        write_reg(CFG_CAMERA_Y, y);
        write_reg(CFG_CAMERA_Z, z);
    endtask

    initial
    begin
        logic [31:0] lim;
        logic [4:0]  used;
        int          words;
        rst_n      = 1'b0;
        calm       = 0;
        stall_now  = 0;
        item.valid <= 1'b0;
        item.mode  <= MODE_LOAD;
        item.plane_slot <= '0;
        item.point_x <= 0; item.point_y <= 0; item.point_z <= 0;
        item.normal_x <= 0; item.normal_y <= 0; item.normal_z <= 0;
        item.dir_x <= 0; item.dir_y <= 0; item.dir_z <= 0;
        cfg.valid  <= 1'b0;
        cfg.addr   <= '0;
        cfg.data   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part. Every slot is loaded first so no trace ever reads
        // an entry that was never written.
        set_camera(0, 0, 0);
        write_reg(CFG_PLANES_IN_USE, 4);
        write_reg(CFG_PARALLEL_LIMIT, PARALLEL_LIMIT_RESET);
        load_plane(0, 0, 0, 10 * ONE, 0, 0, ONE);         // plane z = 10
        load_plane(1, 0, 0, 10 * ONE, 0, 0, ONE);         // same plane, loses the tie
        load_plane(2, 0, 0, -5 * ONE, 0, 0, -ONE);        // z = -5, normal flipped
        load_plane(3, 3 * ONE, 0, 0, ONE, 0, 0);          // plane x = 3
        load_plane(4, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                   32'sh80000000, 32'sh80000000, 32'sh80000000);
        load_plane(5, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                   32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        for (int s = 6; s < PLANES; s++)
            load_plane(4'(s), q_value(), q_value(), q_value(),
                       q_value(), q_value(), q_value());
        trace(0, 0, ONE);           // tie between the first two planes
        trace(0, 0, -ONE);          // only the flipped plane lies ahead
        trace(ONE, 0, 0);           // plane x = 3
        trace(0, ONE, 0);           // parallel to all of them: no hit
        trace(0, 0, 1);             // tiny step, t saturates
        trace(0, 0, 0);
        trace(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
        drain();
        // Origin on plane x = 3 gives t = 0, still a hit.
        set_camera(3 * ONE, 0, 0);
        trace(ONE, 0, 0);
        drain();
        // Count above the table size, no parallel limit, extreme origin.
        set_camera(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        write_reg(CFG_PLANES_IN_USE, 31);
        write_reg(CFG_PARALLEL_LIMIT, 0);
        trace(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
        trace(-ONE, ONE, -ONE);
        drain();

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin used = 4;  lim = PARALLEL_LIMIT_RESET; end
                1: begin used = 16; lim = 0; end
                2: begin used = 2;  lim = 32'hFFFFFFFF; end
                3: begin used = 0;  lim = $urandom; end
                4: begin used = 31; lim = $urandom_range(0, 1 << 20); end
                default:
                begin
                    used = 5'($urandom_range(1, 6));
                    lim  = PARALLEL_LIMIT_RESET;
                end
            endcase
            if (ph == 5)
                set_camera($urandom, $urandom, $urandom);
            else
                set_camera(q_value(), q_value(), q_value());
            write_reg(CFG_PLANES_IN_USE, {27'd0, used});
            write_reg(CFG_PARALLEL_LIMIT, lim);
            calm = (ph == 1);
            words = (used > 6) ? 150 : 330;
            for (int w = 0; w < words; w++)
            begin
                if (ph == 2 && w == 20)
                    stall_now = 1;
                if (ph == 3 && w == 100)
                begin
                    // The sender holds back until every result is in.
                    item.valid <= 1'b0;
                    @(negedge clk);
                    while (pending != 0)
                        @(negedge clk);
                    @(posedge clk);
                end
                if ($urandom_range(0, 99) < 35)
                    load_plane(4'($urandom_range(0, PLANES - 1)), q_value(), q_value(),
                               q_value(), q_value(), q_value(), q_value());
                else
                    trace(q_value(), q_value(), q_value());
            end
            drain();
        end

        // The run ends only once every trace has been answered.
        repeat (50) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
